// ===== src/hpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau package
// Shared constants, datapath commands, status and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpmr_pkg;

  localparam int unsigned PRODUCT_SHIFT = 20;
  localparam logic [63:0] WEIGHT_NUM = 64'h0100_0000_0000_0000;
  localparam logic [63:0] PERR_NUM   = 64'h4000_0000_0000_0000;
  localparam logic [31:0] NEG_CAP    = 32'h8000_0000;
  localparam logic [31:0] POS_CAP    = 32'h7FFF_FFFF;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_XX,
    OP_MUL_CX,
    OP_MUL_CSQL,
    OP_MUL_CSQH,
    OP_MUL_EE,
    OP_ACC_HIST,
    OP_ACC_SQ,
    OP_DIV_W,
    OP_MUL_CWL,
    OP_MUL_CWH,
    OP_ACC_PL,
    OP_ACC_WC,
    OP_DIV_PL,
    OP_DIV_PE,
    OP_SQRT_PE,
    OP_DIV_MN,
    OP_MUL_QQ,
    OP_DIV_M2,
    OP_SQRT_RMS,
    OP_STORE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic plateau_bin;
    logic last_bin;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic [31:0] r;
    r = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

  function automatic logic [63:0] add_sat_u(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

// ===== src/hpmr_if.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau channels
// Bin input, result output and threshold configuration channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hpmr_bin_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] bin_center;
  logic        [31:0] bin_content;
  logic        [31:0] bin_error;
  logic               last_bin;
  modport source (output valid, bin_center, bin_content, bin_error, last_bin, input ready);
  modport sink   (input valid, bin_center, bin_content, bin_error, last_bin, output ready);
endinterface

interface hpmr_res_if;
  logic               valid;
  logic               ready;
  logic        [31:0] plateau;
  logic        [31:0] plateau_error;
  logic signed [31:0] mean;
  logic        [31:0] rms;
  logic               no_plateau_bins;
  logic               empty_histogram;
  modport source (output valid, plateau, plateau_error, mean, rms, no_plateau_bins,
                  empty_histogram, input ready);
  modport sink   (input valid, plateau, plateau_error, mean, rms, no_plateau_bins,
                  empty_histogram, output ready);
endinterface

interface hpmr_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] threshold;
  modport source (output valid, threshold, input ready);
  modport sink   (input valid, threshold, output ready);
endinterface

// ===== src/hpmr_div.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau divider
// Restoring 128 by 64 bit divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpmr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] hi_i,
  input  logic [63:0] lo_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic [63:0] quo_o
);

  logic [63:0] rem_q, lo_q, quo_q, den_q;
  logic        ovf_q, busy_q;
  logic [6:0]  cnt_q;
  logic [64:0] shifted, diff;

  assign shifted = {rem_q, lo_q[63]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 7'd1;
      busy_q <= (cnt_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi_i;
      lo_q  <= lo_i;
      den_q <= den_i;
      quo_q <= 64'd0;
      ovf_q <= (hi_i >= den_i);
    end else if (busy_q) begin
      lo_q <= {lo_q[62:0], 1'b0};
      if (!diff[64]) begin
        rem_q <= diff[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = ovf_q ? 64'hFFFF_FFFF_FFFF_FFFF : quo_q;

endmodule

// ===== src/hpmr_sqrt.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau square root
// Bitwise integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpmr_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        busy_o,
  output logic [63:0] root_o
);

  logic [63:0] v_q, r_q, bit_q, trial;
  logic        busy_q;
  logic [5:0]  cnt_q;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 6'd1;
      busy_q <= (cnt_q != 6'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= 64'd0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      bit_q <= {2'b00, bit_q[63:2]};
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= {1'b0, r_q[63:1]} + bit_q;
      end else begin
        r_q <= {1'b0, r_q[63:1]};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = r_q;

endmodule

// ===== src/hpmr_datapath.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau datapath
// Accumulators, shared multiplier, divider and square root, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpmr_datapath #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpmr_pkg::dp_cmd_t   cmd_i,
  output hpmr_pkg::dp_status_t status_o,
  input  logic signed [31:0]  bin_center_i,
  input  logic        [31:0]  bin_content_i,
  input  logic        [31:0]  bin_error_i,
  input  logic                last_bin_i,
  input  logic                cfg_valid_i,
  input  logic signed [31:0]  cfg_threshold_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic        [31:0]  plateau_o,
  output logic        [31:0]  plateau_error_o,
  output logic signed [31:0]  mean_o,
  output logic        [31:0]  rms_o,
  output logic                no_plateau_bins_o,
  output logic                empty_histogram_o
);

  localparam int unsigned M2HiShift = 64 - FRACTION_BITS;

  logic signed [31:0] thr_q, x_q;
  logic [31:0] c_q, e_q, xmag, mul_a, mul_b, qcap, plat_q, perr_q, mean_q;
  logic        last_q, plb_q, res_valid_q;
  logic [63:0] sq_q, cx_q, plo_q, phi_q, ee_q, term_q, mul_p;
  logic [63:0] wcs_q, ivs_q, ccss_q, ccs_q, smag;
  logic [47:0] cs_q;
  logic [48:0] cs_sum;
  logic [64:0] ccs_add, ccs_sum;
  logic [95:0] full, sh_fb, sh_pr;
  logic [63:0] term_fb, term_pr;
  logic        div_start, sqrt_start, div_busy, sqrt_busy;
  logic [63:0] div_hi, div_lo, div_den, dq, sqrt_val, sr;
  logic        ivs_nz, cs_nz;
  hpmr_pkg::dp_op_e op;

  assign op    = cmd_i.op;
  assign xmag  = x_q[31] ? (~x_q + 32'd1) : x_q;
  assign smag  = ccs_q[63] ? (~ccs_q + 64'd1) : ccs_q;
  assign mul_p = mul_a * mul_b;
  assign ivs_nz = (ivs_q != 64'd0);
  assign cs_nz  = (cs_q != 48'd0);

  always_comb begin
    if (ccs_q[63]) begin
      qcap = (dq > {32'd0, hpmr_pkg::NEG_CAP}) ? hpmr_pkg::NEG_CAP : dq[31:0];
    end else begin
      qcap = (dq > {32'd0, hpmr_pkg::POS_CAP}) ? hpmr_pkg::POS_CAP : dq[31:0];
    end
  end

  assign full    = {phi_q, 32'd0} + {32'd0, plo_q};
  assign sh_fb   = full >> FRACTION_BITS;
  assign sh_pr   = full >> hpmr_pkg::PRODUCT_SHIFT;
  assign term_fb = (sh_fb[95:64] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : sh_fb[63:0];
  assign term_pr = (sh_pr[95:64] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : sh_pr[63:0];

  assign cs_sum  = {1'b0, cs_q} + {17'd0, c_q};
  assign ccs_add = x_q[31] ? (~{1'b0, cx_q} + 65'd1) : {1'b0, cx_q};
  assign ccs_sum = {ccs_q[63], ccs_q} + ccs_add;

  always_comb begin
    mul_a = c_q;
    mul_b = xmag;
    case (op)
      hpmr_pkg::OP_MUL_XX: begin
        mul_a = xmag;
      end
      hpmr_pkg::OP_MUL_CSQL: begin
        mul_b = sq_q[31:0];
      end
      hpmr_pkg::OP_MUL_CSQH: begin
        mul_b = sq_q[63:32];
      end
      hpmr_pkg::OP_MUL_EE: begin
        mul_a = e_q;
        mul_b = e_q;
      end
      hpmr_pkg::OP_MUL_CWL: begin
        mul_b = dq[31:0];
      end
      hpmr_pkg::OP_MUL_CWH: begin
        mul_b = dq[63:32];
      end
      hpmr_pkg::OP_MUL_QQ: begin
        mul_a = qcap;
        mul_b = qcap;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_start  = 1'b0;
    div_hi     = 64'd0;
    div_lo     = hpmr_pkg::PERR_NUM;
    div_den    = ivs_q;
    sqrt_start = 1'b0;
    sqrt_val   = dq;
    case (op)
      hpmr_pkg::OP_DIV_W: begin
        div_start = 1'b1;
        div_lo    = hpmr_pkg::WEIGHT_NUM;
        div_den   = ee_q;
      end
      hpmr_pkg::OP_DIV_PL: begin
        div_start = 1'b1;
        div_hi    = wcs_q >> (64 - hpmr_pkg::PRODUCT_SHIFT);
        div_lo    = wcs_q << hpmr_pkg::PRODUCT_SHIFT;
      end
      hpmr_pkg::OP_DIV_PE: begin
        div_start = 1'b1;
      end
      hpmr_pkg::OP_DIV_MN: begin
        div_start = 1'b1;
        div_lo    = smag;
        div_den   = {16'd0, cs_q};
      end
      hpmr_pkg::OP_DIV_M2: begin
        div_start = 1'b1;
        div_hi    = ccss_q >> M2HiShift;
        div_lo    = ccss_q << FRACTION_BITS;
        div_den   = {16'd0, cs_q};
      end
      hpmr_pkg::OP_SQRT_PE: begin
        sqrt_start = 1'b1;
      end
      hpmr_pkg::OP_SQRT_RMS: begin
        sqrt_start = 1'b1;
        sqrt_val   = (dq > sq_q) ? (dq - sq_q) : 64'd0;
      end
      default: begin
      end
    endcase
  end

  hpmr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (dq)
  );

  hpmr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sqrt_val),
    .busy_o  (sqrt_busy),
    .root_o  (sr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= 32'sd0;
      wcs_q       <= 64'd0;
      ivs_q       <= 64'd0;
      cs_q        <= 48'd0;
      ccs_q       <= 64'd0;
      ccss_q      <= 64'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_threshold_i;
      end
      if (op == hpmr_pkg::OP_STORE) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (op)
        hpmr_pkg::OP_ACC_HIST: begin
          cs_q <= cs_sum[48] ? 48'hFFFF_FFFF_FFFF : cs_sum[47:0];
          if (ccs_sum[64] != ccs_sum[63]) begin
            ccs_q <= ccs_sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          end else begin
            ccs_q <= ccs_sum[63:0];
          end
        end
        hpmr_pkg::OP_ACC_SQ: begin
          ccss_q <= hpmr_pkg::add_sat_u(ccss_q, term_q);
        end
        hpmr_pkg::OP_ACC_PL: begin
          ivs_q <= hpmr_pkg::add_sat_u(ivs_q, dq);
        end
        hpmr_pkg::OP_ACC_WC: begin
          wcs_q <= hpmr_pkg::add_sat_u(wcs_q, term_q);
        end
        hpmr_pkg::OP_STORE: begin
          wcs_q  <= 64'd0;
          ivs_q  <= 64'd0;
          cs_q   <= 48'd0;
          ccs_q  <= 64'd0;
          ccss_q <= 64'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      hpmr_pkg::OP_LOAD: begin
        x_q    <= bin_center_i;
        c_q    <= bin_content_i;
        e_q    <= bin_error_i;
        last_q <= last_bin_i;
        plb_q  <= (bin_center_i > thr_q) && (bin_content_i != 32'd0)
                  && (bin_error_i != 32'd0);
      end
      hpmr_pkg::OP_MUL_XX: begin
        sq_q <= mul_p;
      end
      hpmr_pkg::OP_MUL_CX: begin
        cx_q <= mul_p;
      end
      hpmr_pkg::OP_MUL_CSQL, hpmr_pkg::OP_MUL_CWL: begin
        plo_q <= mul_p;
      end
      hpmr_pkg::OP_MUL_CSQH, hpmr_pkg::OP_MUL_CWH: begin
        phi_q <= mul_p;
      end
      hpmr_pkg::OP_MUL_EE: begin
        ee_q <= mul_p;
      end
      hpmr_pkg::OP_ACC_HIST: begin
        term_q <= term_fb;
      end
      hpmr_pkg::OP_ACC_PL: begin
        term_q <= term_pr;
      end
      hpmr_pkg::OP_DIV_PE: begin
        plat_q <= hpmr_pkg::sat32(dq);
      end
      hpmr_pkg::OP_DIV_MN: begin
        perr_q <= hpmr_pkg::sat32({3'd0, sr[63:3]});
      end
      hpmr_pkg::OP_MUL_QQ: begin
        sq_q   <= mul_p;
        mean_q <= ccs_q[63] ? (~qcap + 32'd1) : qcap;
      end
      hpmr_pkg::OP_STORE: begin
        plateau_o         <= ivs_nz ? plat_q : 32'd0;
        plateau_error_o   <= ivs_nz ? perr_q : 32'd0;
        mean_o            <= cs_nz ? mean_q : 32'sd0;
        rms_o             <= cs_nz ? hpmr_pkg::sat32(sr) : 32'd0;
        no_plateau_bins_o <= !ivs_nz;
        empty_histogram_o <= !cs_nz;
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o          = res_valid_q;
  assign status_o.plateau_bin = plb_q;
  assign status_o.last_bin    = last_q;
  assign status_o.div_busy    = div_busy;
  assign status_o.sqrt_busy   = sqrt_busy;
  assign status_o.out_free    = !res_valid_q || res_ready_i;

endmodule

// ===== src/hpmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau controller
// Sequences the datapath through bin accumulation and the final results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpmr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 bin_valid_i,
  output logic                 bin_ready_o,
  input  hpmr_pkg::dp_status_t status_i,
  output hpmr_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [27:0] {
    S_IDLE  = 28'd1 << 0,
    S_MXX   = 28'd1 << 1,
    S_MCX   = 28'd1 << 2,
    S_MSQL  = 28'd1 << 3,
    S_MSQH  = 28'd1 << 4,
    S_MEE   = 28'd1 << 5,
    S_ACCH  = 28'd1 << 6,
    S_ACCH2 = 28'd1 << 7,
    S_DIVW  = 28'd1 << 8,
    S_WAITW = 28'd1 << 9,
    S_MCWL  = 28'd1 << 10,
    S_MCWH  = 28'd1 << 11,
    S_ACCP  = 28'd1 << 12,
    S_ACCP2 = 28'd1 << 13,
    S_DIVPL = 28'd1 << 14,
    S_WPL   = 28'd1 << 15,
    S_DIVPE = 28'd1 << 16,
    S_WPE   = 28'd1 << 17,
    S_SQPE  = 28'd1 << 18,
    S_WSQPE = 28'd1 << 19,
    S_DIVMN = 28'd1 << 20,
    S_WMN   = 28'd1 << 21,
    S_MQQ   = 28'd1 << 22,
    S_DIVM2 = 28'd1 << 23,
    S_WM2   = 28'd1 << 24,
    S_SQRMS = 28'd1 << 25,
    S_WRMS  = 28'd1 << 26,
    S_STORE = 28'd1 << 27
  } state_e;

  state_e state_q, state_d;
  hpmr_pkg::dp_op_e op;

  always_comb begin
    state_d     = state_q;
    op          = hpmr_pkg::OP_NONE;
    bin_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        bin_ready_o = 1'b1;
        if (bin_valid_i) begin
          op      = hpmr_pkg::OP_LOAD;
          state_d = S_MXX;
        end
      end
      S_MXX: begin
        op      = hpmr_pkg::OP_MUL_XX;
        state_d = S_MCX;
      end
      S_MCX: begin
        op      = hpmr_pkg::OP_MUL_CX;
        state_d = S_MSQL;
      end
      S_MSQL: begin
        op      = hpmr_pkg::OP_MUL_CSQL;
        state_d = S_MSQH;
      end
      S_MSQH: begin
        op      = hpmr_pkg::OP_MUL_CSQH;
        state_d = S_MEE;
      end
      S_MEE: begin
        op      = hpmr_pkg::OP_MUL_EE;
        state_d = S_ACCH;
      end
      S_ACCH: begin
        op      = hpmr_pkg::OP_ACC_HIST;
        state_d = S_ACCH2;
      end
      S_ACCH2: begin
        op = hpmr_pkg::OP_ACC_SQ;
        if (status_i.plateau_bin) begin
          state_d = S_DIVW;
        end else if (status_i.last_bin) begin
          state_d = S_DIVPL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIVW: begin
        op      = hpmr_pkg::OP_DIV_W;
        state_d = S_WAITW;
      end
      S_WAITW: begin
        if (!status_i.div_busy) begin
          state_d = S_MCWL;
        end
      end
      S_MCWL: begin
        op      = hpmr_pkg::OP_MUL_CWL;
        state_d = S_MCWH;
      end
      S_MCWH: begin
        op      = hpmr_pkg::OP_MUL_CWH;
        state_d = S_ACCP;
      end
      S_ACCP: begin
        op      = hpmr_pkg::OP_ACC_PL;
        state_d = S_ACCP2;
      end
      S_ACCP2: begin
        op      = hpmr_pkg::OP_ACC_WC;
        state_d = status_i.last_bin ? S_DIVPL : S_IDLE;
      end
      S_DIVPL: begin
        op      = hpmr_pkg::OP_DIV_PL;
        state_d = S_WPL;
      end
      S_WPL: begin
        if (!status_i.div_busy) begin
          state_d = S_DIVPE;
        end
      end
      S_DIVPE: begin
        op      = hpmr_pkg::OP_DIV_PE;
        state_d = S_WPE;
      end
      S_WPE: begin
        if (!status_i.div_busy) begin
          state_d = S_SQPE;
        end
      end
      S_SQPE: begin
        op      = hpmr_pkg::OP_SQRT_PE;
        state_d = S_WSQPE;
      end
      S_WSQPE: begin
        if (!status_i.sqrt_busy) begin
          state_d = S_DIVMN;
        end
      end
      S_DIVMN: begin
        op      = hpmr_pkg::OP_DIV_MN;
        state_d = S_WMN;
      end
      S_WMN: begin
        if (!status_i.div_busy) begin
          state_d = S_MQQ;
        end
      end
      S_MQQ: begin
        op      = hpmr_pkg::OP_MUL_QQ;
        state_d = S_DIVM2;
      end
      S_DIVM2: begin
        op      = hpmr_pkg::OP_DIV_M2;
        state_d = S_WM2;
      end
      S_WM2: begin
        if (!status_i.div_busy) begin
          state_d = S_SQRMS;
        end
      end
      S_SQRMS: begin
        op      = hpmr_pkg::OP_SQRT_RMS;
        state_d = S_WRMS;
      end
      S_WRMS: begin
        if (!status_i.sqrt_busy) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        if (status_i.out_free) begin
          op      = hpmr_pkg::OP_STORE;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.op = op;

endmodule

// ===== src/histogram_plateau_mean_rms_unit.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau, mean and RMS unit
// Streams histogram bins and reports plateau, its error, mean and RMS.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// bin_i    in   bin_center, bin_content, bin_error, last_bin
// res_o    out  plateau, plateau_error, mean, rms, no_plateau_bins,
//               empty_histogram
// cfg_i    in   threshold
//
// A plateau bin also runs the weight division in the shared divider and
// so takes longer than a bin outside the plateau.
// The last bin adds four divisions and two square roots, which run
// back to back on the shared units.
// Reset clears all sums and the threshold. A stalled result waits in the
// output register while the next histogram is accumulated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module histogram_plateau_mean_rms_unit #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hpmr_bin_if.sink    bin_i,
  hpmr_res_if.source  res_o,
  hpmr_cfg_if.sink    cfg_i
);

  hpmr_pkg::dp_cmd_t    cmd;
  hpmr_pkg::dp_status_t status;

  assign cfg_i.ready = 1'b1;

  hpmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bin_valid_i (bin_i.valid),
    .bin_ready_o (bin_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hpmr_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .bin_center_i      (bin_i.bin_center),
    .bin_content_i     (bin_i.bin_content),
    .bin_error_i       (bin_i.bin_error),
    .last_bin_i        (bin_i.last_bin),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_threshold_i   (cfg_i.threshold),
    .res_valid_o       (res_o.valid),
    .res_ready_i       (res_o.ready),
    .plateau_o         (res_o.plateau),
    .plateau_error_o   (res_o.plateau_error),
    .mean_o            (res_o.mean),
    .rms_o             (res_o.rms),
    .no_plateau_bins_o (res_o.no_plateau_bins),
    .empty_histogram_o (res_o.empty_histogram)
  );

endmodule

// ===== src/hpmr_checker.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau checker
// Port-level assertions on the result channel and the bin handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        bin_valid_i,
  input logic        bin_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] plateau_i,
  input logic [31:0] plateau_error_i,
  input logic [31:0] mean_i,
  input logic [31:0] rms_i,
  input logic        no_plateau_bins_i,
  input logic        empty_histogram_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result item dropped while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && empty_histogram_i |-> mean_i == 32'd0 && rms_i == 32'd0)
    else $error("empty histogram with nonzero mean or rms");

  a_noplat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && no_plateau_bins_i |-> plateau_i == 32'd0 && plateau_error_i == 32'd0)
    else $error("empty plateau with nonzero plateau outputs");

  a_bin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_valid_i && bin_ready_i |=> !bin_ready_i)
    else $error("bin item accepted while previous item in work");

endmodule

bind histogram_plateau_mean_rms_unit hpmr_checker u_hpmr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .bin_valid_i       (bin_i.valid),
  .bin_ready_i       (bin_i.ready),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .plateau_i         (res_o.plateau),
  .plateau_error_i   (res_o.plateau_error),
  .mean_i            (res_o.mean),
  .rms_i             (res_o.rms),
  .no_plateau_bins_i (res_o.no_plateau_bins),
  .empty_histogram_i (res_o.empty_histogram)
);

// ===== tb/sv/tb_histogram_plateau_mean_rms_unit.sv =====
// ----------------------------------------------------------------------------
// Histogram plateau unit testbench
// Streams directed and random histograms through the unit under several
// thresholds and checks every result against a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [31:0] center;
  logic        [31:0] content;
  logic        [31:0] error;
  logic               last;
} bin_item_t;

typedef struct packed {
  logic [31:0]        plateau;
  logic [31:0]        plateau_error;
  logic signed [31:0] mean;
  logic [31:0]        rms;
  logic               no_plateau_bins;
  logic               empty_histogram;
} hist_result_t;

class hist_scoreboard;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CONTENT_CAP = 64'h0000_FFFF_FFFF_FFFF;

  logic signed [31:0] threshold;
  logic [63:0]        weighted_sum;
  logic [63:0]        weight_sum;
  logic [63:0]        content_total;
  logic signed [63:0] moment1_sum;
  logic [63:0]        moment2_sum;
  hist_result_t       pending[$];
  int                 errors;

  function new();
    threshold = 0;
    errors = 0;
    clear();
  endfunction

  function void clear();
    weighted_sum = 0;
    weight_sum = 0;
    content_total = 0;
    moment1_sum = 0;
    moment2_sum = 0;
  endfunction

  function logic [63:0] add_u(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? U64_MAX : s[63:0];
  endfunction

  function logic [63:0] sat64(logic [127:0] v);
    return (v[127:64] != 0) ? U64_MAX : v[63:0];
  endfunction

  function logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function void note_bin(bin_item_t it);
    logic signed [63:0] x;
    logic [63:0]        c;
    logic [63:0]        e;
    logic [63:0]        xmag;
    logic [63:0]        w;
    logic [63:0]        prod;
    logic signed [64:0] s1;
    logic [127:0]       wide;
    logic [63:0]        q;
    logic [63:0]        smag;
    logic [63:0]        qmag;
    logic [63:0]        m2;
    logic [63:0]        r;
    hist_result_t       res;
    x = it.center;
    c = {32'd0, it.content};
    e = {32'd0, it.error};
    xmag = (x < 0) ? -x : x;
    if (x > threshold && c != 0 && e != 0) begin
      w = 64'h0100_0000_0000_0000 / (e * e);
      wide = {64'd0, c} * {64'd0, w};
      weighted_sum = add_u(weighted_sum, sat64(wide >> 20));
      weight_sum = add_u(weight_sum, w);
    end
    content_total = content_total + c;
    if (content_total > CONTENT_CAP) content_total = CONTENT_CAP;
    prod = c * xmag;
    s1 = {moment1_sum[63], moment1_sum} + ((x < 0) ? -{1'b0, prod} : {1'b0, prod});
    if (s1 > 65'sh0_7FFF_FFFF_FFFF_FFFF) moment1_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (s1 < -65'sh0_8000_0000_0000_0000) moment1_sum = 64'sh8000_0000_0000_0000;
    else moment1_sum = s1[63:0];
    wide = {64'd0, c} * {64'd0, xmag * xmag};
    moment2_sum = add_u(moment2_sum, sat64(wide >> 16));
    if (!it.last) return;
    res = '0;
    if (weight_sum != 0) begin
      q = sat64({44'd0, weighted_sum, 20'd0} / {64'd0, weight_sum});
      res.plateau = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      r = isqrt(64'h4000_0000_0000_0000 / weight_sum) >> 3;
      res.plateau_error = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    end
    if (content_total != 0) begin
      smag = (moment1_sum < 0) ? -moment1_sum : moment1_sum;
      qmag = smag / content_total;
      if (moment1_sum < 0) begin
        if (qmag > 64'h8000_0000) qmag = 64'h8000_0000;
        res.mean = -qmag[31:0];
      end else begin
        if (qmag > 64'h7FFF_FFFF) qmag = 64'h7FFF_FFFF;
        res.mean = qmag[31:0];
      end
      m2 = sat64({48'd0, moment2_sum, 16'd0} / {64'd0, content_total});
      r = (m2 > qmag * qmag) ? isqrt(m2 - qmag * qmag) : 64'd0;
      res.rms = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    end
    res.no_plateau_bins = (weight_sum == 0);
    res.empty_histogram = (content_total == 0);
    pending = {pending, res};
    clear();
  endfunction

  function void check_result(hist_result_t got);
    hist_result_t exp;
    if (pending.size() == 0) begin
      $error("result with no expected result waiting");
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.plateau !== exp.plateau) begin
      $error("plateau: expected %h, got %h", exp.plateau, got.plateau);
      errors++;
    end
    if (got.plateau_error !== exp.plateau_error) begin
      $error("plateau_error: expected %h, got %h", exp.plateau_error, got.plateau_error);
      errors++;
    end
    if (got.mean !== exp.mean) begin
      $error("mean: expected %h, got %h", exp.mean, got.mean);
      errors++;
    end
    if (got.rms !== exp.rms) begin
      $error("rms: expected %h, got %h", exp.rms, got.rms);
      errors++;
    end
    if (got.no_plateau_bins !== exp.no_plateau_bins) begin
      $error("no_plateau_bins: expected %b, got %b", exp.no_plateau_bins,
             got.no_plateau_bins);
      errors++;
    end
    if (got.empty_histogram !== exp.empty_histogram) begin
      $error("empty_histogram: expected %b, got %b", exp.empty_histogram,
             got.empty_histogram);
      errors++;
    end
  endfunction
endclass

module tb_histogram_plateau_mean_rms_unit;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 450;

  logic clk_i;
  logic rst_ni;
  int   cycle_count;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   bins_sent;

  hpmr_bin_if bin_if ();
  hpmr_res_if res_if ();
  hpmr_cfg_if cfg_if ();

  hist_scoreboard sb;

  histogram_plateau_mean_rms_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .bin_i (bin_if.sink),
    .res_o (res_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result('{res_if.plateau, res_if.plateau_error, res_if.mean, res_if.rms,
                        res_if.no_plateau_bins, res_if.empty_histogram});
    end
    res_if.ready <= (rst_ni === 1'b1) && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_bin(bin_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      bin_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    bin_if.valid <= 1'b1;
    bin_if.bin_center <= it.center;
    bin_if.bin_content <= it.content;
    bin_if.bin_error <= it.error;
    bin_if.last_bin <= it.last;
    do @(posedge clk_i); while (!bin_if.ready);
    sb.note_bin(it);
    bins_sent++;
  endtask

  task automatic end_stream();
    bin_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    end_stream();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic signed [31:0] value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.threshold <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.threshold = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic bin_item_t mk(logic [31:0] x, logic [31:0] c, logic [31:0] e,
                                   logic l);
    bin_item_t it;
    it.center = x;
    it.content = c;
    it.error = e;
    it.last = l;
    return it;
  endfunction

  function automatic bin_item_t random_bin(logic l);
    bin_item_t it;
    case ($urandom_range(3))
      0: it.center = $urandom;
      default: it.center = $signed($urandom_range(32'h00A0_0000)) - 32'sh0050_0000;
    endcase
    case ($urandom_range(7))
      0: it.content = 0;
      1: it.content = $urandom;
      default: it.content = $urandom_range(32'h0100_0000);
    endcase
    case ($urandom_range(7))
      0: it.error = 0;
      1: it.error = $urandom;
      default: it.error = $urandom_range(32'h0004_0000, 1);
    endcase
    it.last = l;
    return it;
  endfunction

  task automatic random_histograms(int n_bins);
    int target;
    int len;
    target = bins_sent + n_bins;
    while (bins_sent < target) begin
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        send_bin(random_bin(i == len - 1 || $urandom_range(49) == 0));
      end
    end
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    bins_sent = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_ni <= 1'b0;
    bin_if.valid <= 1'b0;
    bin_if.bin_center <= '0;
    bin_if.bin_content <= '0;
    bin_if.bin_error <= '0;
    bin_if.last_bin <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.threshold <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_bin(mk(32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 1'b1));
    send_bin(mk(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
    send_bin(mk(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    send_bin(mk(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_bin(mk(32'h0002_0000, 32'h0003_0000, 32'hFFFF_FFFF, 1'b1));
    send_bin(mk(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    send_bin(mk(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    send_bin(mk(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1));
    send_bin(mk(32'h0005_0000, 32'h0001_0000, 32'h0000_8000, 1'b0));
    send_bin(mk(32'h0005_0000, 32'h0001_0000, 32'h0000_8000, 1'b0));
    send_bin(mk(32'h0005_0000, 32'h0001_0000, 32'h0000_0000, 1'b1));
    send_bin(mk(32'hFFFF_0000, 32'h0000_0001, 32'h0000_0001, 1'b1));
    send_bin(mk(32'h0000_0001, 32'h0000_0003, 32'h0000_0002, 1'b0));
    send_bin(mk(32'h0000_0002, 32'h0000_0003, 32'h0000_0002, 1'b1));
    send_bin(mk(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    send_bin(mk(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1));

    write_threshold(32'sh8000_0000);
    send_bin(mk(32'h8000_0000, 32'h0001_0000, 32'h0000_1000, 1'b0));
    send_bin(mk(32'h8000_0001, 32'h0001_0000, 32'h0000_1000, 1'b1));
    write_threshold(32'sh7FFF_FFFF);
    send_bin(mk(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_1000, 1'b1));

    write_threshold(32'sh0000_0000);
    tx_idle_pct = 6;
    rx_idle_pct = 66;
    random_histograms(450);
    wait_idle();
    random_histograms(200);
    write_threshold($urandom);
    tx_idle_pct = 66;
    rx_idle_pct = 6;
    random_histograms(650);
    write_threshold($signed($urandom_range(32'h00A0_0000)) - 32'sh0050_0000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_histograms(650);

    wait_idle();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
